[design/pmst_pkg.sv]
// Shared types and constants for the Prim minimum spanning tree block.
// Used by pmst_ctrl, pmst_dp and prim_minimum_spanning_tree_top; no dependencies.
package pmst_pkg;

  // default sizing
  localparam int MAX_NODES_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed field widths of the stream ports
  localparam int NODE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int TOTAL_W  = 21;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 56;

  // node_count after reset
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 6'd32;

  // result status codes
  localparam logic ST_TREE_EDGE     = 1'b0;
  localparam logic ST_NOT_CONNECTED = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_INIT,
    OP_FIND,
    OP_PICK,
    OP_UPD,
    OP_NEXT,
    OP_ESCAN,
    OP_ELOAD,
    OP_FAIL
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;    // clear sweep at final address
    logic scan_done;   // node scan finished and pipeline drained
    logic found;       // an unvisited node with finite key was found
    logic last_round;  // current round is the final one
    logic emit_end;    // emission index reached node count
    logic hp_cur;      // node at emission index has a tree parent
    logic out_free;    // output register can take a beat
  } stat_t;

endpackage

[design/prim_minimum_spanning_tree_top.sv]
// Sequence: one beat per cycle while loading edges; after the beat with tlast, n rounds of
// two node scans (find, then key update), then one result beat per tree edge, skipping nodes
// without parent, or a single not-connected beat if no node is found; a result beat waits on
// out_tready while the result register is full.
// Throughput: one graph at a time; after each graph a clear sweep over all weight matrix
// addresses blocks input. Reset (rst_n low, synchronous) starts that sweep.
// Depends on pmst_pkg, pmst_ctrl, pmst_dp.
module prim_minimum_spanning_tree_top #(
  parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmst_pkg::NODE_W-1:0]   cfg_data,   // node_count
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pmst_pkg::IN_DW-1:0]    in_tdata,   // end_a, end_b, edge_weight, zero pad
  input  logic                          in_tlast,   // last_edge
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pmst_pkg::OUT_DW-1:0]   out_tdata,  // parent_node, child_node,
                                                    // tree_edge_weight, running_total, pad
  output logic                          out_tuser,  // status
  output logic                          out_tlast   // last_result
);

  pmst_pkg::cmd_t  cmd;
  pmst_pkg::stat_t stat;

  logic [pmst_pkg::NODE_W-1:0]   res_parent, res_child;
  logic [pmst_pkg::WEIGHT_W-1:0] res_weight;
  logic [pmst_pkg::TOTAL_W-1:0]  res_total;

  pmst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pmst_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .cfg_ready   (cfg_ready),
    .end_a       (in_tdata[5:0]),
    .end_b       (in_tdata[11:6]),
    .edge_weight (in_tdata[27:12]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .res_status  (out_tuser),
    .res_parent  (res_parent),
    .res_child   (res_child),
    .res_weight  (res_weight),
    .res_total   (res_total),
    .res_last    (out_tlast)
  );

  // pack the result beat, lowest field first
  assign out_tdata = {7'd0, res_total, res_weight, res_child, res_parent};

endmodule

[design/pmst_ctrl.sv]
// Controller state machine for the Prim minimum spanning tree block.
// Depends on pmst_pkg; drives pmst_dp through cmd_t and reads stat_t.
module pmst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tlast,
  output logic           in_tready,
  input  pmst_pkg::stat_t stat,
  output pmst_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_LOAD,
    S_INIT,
    S_FIND,
    S_PICK,
    S_UPD,
    S_NEXT,
    S_ESCAN,
    S_ELOAD,
    S_FAIL
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_LOAD);
  assign accept    = in_tvalid & in_tready;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = pmst_pkg::OP_NOP;
    case (state_r)
      S_CLEAR: begin
        cmd.op = pmst_pkg::OP_CLR;
        if (stat.clr_last) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (accept) begin
          cmd.op = pmst_pkg::OP_LOAD;
          if (in_tlast) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op    = pmst_pkg::OP_INIT;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        cmd.op = pmst_pkg::OP_FIND;
        if (stat.scan_done) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (stat.found) begin
          cmd.op    = pmst_pkg::OP_PICK;
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_UPD: begin
        cmd.op = pmst_pkg::OP_UPD;
        if (stat.scan_done) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.op    = pmst_pkg::OP_NEXT;
        state_nxt = stat.last_round ? S_ESCAN : S_FIND;
      end
      S_ESCAN: begin
        cmd.op = pmst_pkg::OP_ESCAN;
        if (stat.emit_end) state_nxt = S_CLEAR;
        else if (stat.hp_cur) state_nxt = S_ELOAD;
      end
      S_ELOAD: begin
        if (stat.out_free) begin
          cmd.op    = pmst_pkg::OP_ELOAD;
          state_nxt = S_ESCAN;
        end
      end
      S_FAIL: begin
        if (stat.out_free) begin
          cmd.op    = pmst_pkg::OP_FAIL;
          state_nxt = S_CLEAR;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state register; reset starts the matrix clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/pmst_dp.sv]
// Datapath for the Prim minimum spanning tree block: weight matrix, key and
// parent memories, node scans and result register. Depends on pmst_pkg.
module pmst_dp #(
  parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmst_pkg::cmd_t                cmd,
  output pmst_pkg::stat_t               stat,
  input  logic                          cfg_valid,
  input  logic [pmst_pkg::NODE_W-1:0]   cfg_data,
  output logic                          cfg_ready,
  input  logic [pmst_pkg::NODE_W-1:0]   end_a,
  input  logic [pmst_pkg::NODE_W-1:0]   end_b,
  input  logic [pmst_pkg::WEIGHT_W-1:0] edge_weight,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          res_status,
  output logic [pmst_pkg::NODE_W-1:0]   res_parent,
  output logic [pmst_pkg::NODE_W-1:0]   res_child,
  output logic [pmst_pkg::WEIGHT_W-1:0] res_weight,
  output logic [pmst_pkg::TOTAL_W-1:0]  res_total,
  output logic                          res_last
);

  localparam int NB    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int AW    = 2 * NB;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = WEIGHT_BITS + 1;
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  // memories
  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic [KW-1:0]          kmem [MAX_NODES];
  logic [NB-1:0]          pmem [MAX_NODES];
  logic [WEIGHT_BITS-1:0] wrd_r;
  logic [KW-1:0]          krd_r;
  logic [NB-1:0]          prd_r;

  logic [pmst_pkg::NODE_W-1:0]  node_count_r;
  logic [MAX_NODES-1:0]         hp_r, intr_r;
  logic [CW-1:0]                idx_r, round_r;
  logic                         vld_d_r;
  logic [NB-1:0]                idx_d_r;
  logic [KW-1:0]                mn_r;
  logic [NB-1:0]                u_r;
  logic                         found_r;
  logic [AW-1:0]                clr_r;
  logic [pmst_pkg::TOTAL_W-1:0] total_r;

  logic                          out_vld_r, o_st_r, o_last_r;
  logic [pmst_pkg::NODE_W-1:0]   o_par_r, o_ch_r;
  logic [pmst_pkg::WEIGHT_W-1:0] o_w_r;
  logic [pmst_pkg::TOTAL_W-1:0]  o_tot_r;

  logic [CW-1:0]          n_eff;
  logic [NB-1:0]          idx_i, a_i, b_i, lo_i, hi_i;
  logic                   load_ok, scan_iss, emit_iss, out_free;
  logic [KW-1:0]          key_eff;
  logic                   upd_hit;
  logic [MAX_NODES-1:0]   hp_above;
  logic                   is_last;
  logic [NB-1:0]          ulo, uhi;

  // effective node count, clamped to 1..MAX_NODES
  always_comb begin
    if (node_count_r == '0) n_eff = CW'(1);
    else if (int'(node_count_r) > MAX_NODES) n_eff = CW'(MAX_NODES);
    else n_eff = CW'(node_count_r);
  end

  assign cfg_ready = 1'b1;

  // edge endpoints, stored once at (min, max)
  assign load_ok = (end_a != '0) && (int'(end_a) <= int'(n_eff)) &&
                   (end_b != '0) && (int'(end_b) <= int'(n_eff));
  assign a_i  = NB'(end_a - pmst_pkg::NODE_W'(1));
  assign b_i  = NB'(end_b - pmst_pkg::NODE_W'(1));
  assign lo_i = (a_i < b_i) ? a_i : b_i;
  assign hi_i = (a_i < b_i) ? b_i : a_i;

  assign idx_i    = idx_r[NB-1:0];
  assign ulo      = (u_r < idx_i) ? u_r : idx_i;
  assign uhi      = (u_r < idx_i) ? idx_i : u_r;
  assign scan_iss = ((cmd.op == pmst_pkg::OP_FIND) || (cmd.op == pmst_pkg::OP_UPD)) &&
                    (idx_r < n_eff);
  assign emit_iss = (cmd.op == pmst_pkg::OP_ESCAN) && (idx_r != n_eff) && hp_r[idx_i];
  assign out_free = !out_vld_r || out_tready;

  // key seen at the second scan stage; unwritten keys read as infinite, the root's as zero
  always_comb begin
    if (hp_r[idx_d_r]) key_eff = krd_r;
    else if (idx_d_r == '0) key_eff = '0;
    else key_eff = KEY_INF;
  end

  assign upd_hit = (cmd.op == pmst_pkg::OP_UPD) && vld_d_r && (wrd_r != '0) &&
                   !intr_r[idx_d_r] && (key_eff > {1'b0, wrd_r});

  // final tree edge: no parent set above the current child
  assign hp_above = hp_r >> idx_i;
  assign is_last  = (hp_above >> 1) == '0;

  // status back to the controller
  always_comb begin
    stat.clr_last   = (clr_r == '1);
    stat.scan_done  = (idx_r == n_eff) && !vld_d_r;
    stat.found      = found_r;
    stat.last_round = ((round_r + CW'(1)) == n_eff);
    stat.emit_end   = (idx_r == n_eff);
    stat.hp_cur     = hp_r[idx_i];
    stat.out_free   = out_free;
  end

  // weight matrix: one write, one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.op == pmst_pkg::OP_CLR) begin
      wmem[clr_r] <= '0;
    end else if ((cmd.op == pmst_pkg::OP_LOAD) && load_ok) begin
      wmem[{lo_i, hi_i}] <= WEIGHT_BITS'(edge_weight);
    end
    if (scan_iss) wrd_r <= wmem[{ulo, uhi}];
  end

  // key and parent memories
  always_ff @(posedge clk) begin
    if (upd_hit) begin
      kmem[idx_d_r] <= {1'b0, wrd_r};
      pmem[idx_d_r] <= u_r;
    end
    if (scan_iss || emit_iss) begin
      krd_r <= kmem[idx_i];
      prd_r <= pmem[idx_i];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= pmst_pkg::NODE_COUNT_RST;
    end else if (cfg_valid) begin
      node_count_r <= cfg_data;
    end
  end

  // scan control, tree state and running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      hp_r    <= '0;
      intr_r  <= '0;
      idx_r   <= '0;
      round_r <= '0;
      vld_d_r <= 1'b0;
      found_r <= 1'b0;
      total_r <= '0;
    end else begin
      vld_d_r <= scan_iss;
      if (scan_iss) idx_d_r <= idx_i;
      if (upd_hit) hp_r[idx_d_r] <= 1'b1;
      if ((cmd.op == pmst_pkg::OP_FIND) && vld_d_r && !intr_r[idx_d_r] && (key_eff < mn_r))
      begin
        mn_r    <= key_eff;
        u_r     <= idx_d_r;
        found_r <= 1'b1;
      end
      case (cmd.op)
        pmst_pkg::OP_CLR: clr_r <= clr_r + AW'(1);
        pmst_pkg::OP_INIT: begin
          hp_r    <= '0;
          intr_r  <= '0;
          idx_r   <= '0;
          round_r <= '0;
          mn_r    <= KEY_INF;
          found_r <= 1'b0;
          total_r <= '0;
        end
        pmst_pkg::OP_FIND, pmst_pkg::OP_UPD: begin
          if (scan_iss) idx_r <= idx_r + CW'(1);
        end
        pmst_pkg::OP_PICK: begin
          intr_r[u_r] <= 1'b1;
          idx_r       <= '0;
        end
        pmst_pkg::OP_NEXT: begin
          round_r <= round_r + CW'(1);
          idx_r   <= '0;
          mn_r    <= KEY_INF;
          found_r <= 1'b0;
        end
        pmst_pkg::OP_ESCAN: begin
          if ((idx_r != n_eff) && !hp_r[idx_i]) idx_r <= idx_r + CW'(1);
        end
        pmst_pkg::OP_ELOAD: begin
          total_r <= total_r + pmst_pkg::TOTAL_W'(krd_r);
          idx_r   <= idx_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.op == pmst_pkg::OP_ELOAD) begin
      out_vld_r <= 1'b1;
      o_st_r    <= pmst_pkg::ST_TREE_EDGE;
      o_par_r   <= pmst_pkg::NODE_W'(prd_r) + pmst_pkg::NODE_W'(1);
      o_ch_r    <= pmst_pkg::NODE_W'(idx_r) + pmst_pkg::NODE_W'(1);
      o_w_r     <= pmst_pkg::WEIGHT_W'(krd_r);
      o_tot_r   <= total_r + pmst_pkg::TOTAL_W'(krd_r);
      o_last_r  <= is_last;
    end else if (cmd.op == pmst_pkg::OP_FAIL) begin
      out_vld_r <= 1'b1;
      o_st_r    <= pmst_pkg::ST_NOT_CONNECTED;
      o_par_r   <= '0;
      o_ch_r    <= '0;
      o_w_r     <= '0;
      o_tot_r   <= '0;
      o_last_r  <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign res_status = o_st_r;
  assign res_parent = o_par_r;
  assign res_child  = o_ch_r;
  assign res_weight = o_w_r;
  assign res_total  = o_tot_r;
  assign res_last   = o_last_r;

  // a result is only loaded when the register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == pmst_pkg::OP_ELOAD) || (cmd.op == pmst_pkg::OP_FAIL)) |-> out_free)
    else $error("result loaded over a pending beat");

  // the root never gets a parent
  a_root_parent: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pmst_pkg::OP_UPD) |=> !hp_r[0])
    else $error("root node got a parent");

  // a picked node is in the tree afterward
  a_pick_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == pmst_pkg::OP_PICK) |=> intr_r[$past(u_r)])
    else $error("picked node not marked in tree");

endmodule
